// File: src/pcor_pkg.sv
package pcor_pkg;

   // LCG and seed constants
   localparam logic [31:0] LCG_MUL  = 32'd1664525;
   localparam logic [31:0] LCG_ADD  = 32'd1013904223;
   localparam logic [31:0] SEED_MIX = 32'h9E3779B9;

   // Q30 unit and sine polynomial coefficients
   localparam logic [30:0] Q30_ONE = 31'd1073741824;
   localparam logic [30:0] SIN_A1  = 31'd1686629713;
   localparam logic [30:0] SIN_A3  = 31'd693598669;
   localparam logic [30:0] SIN_A5  = 31'd85569306;
   localparam logic [30:0] SIN_A7  = 31'd5026995;
   localparam logic [30:0] SIN_A9  = 31'd172272;

   // Pipeline depths
   localparam int SIN_LAT     = 6;
   localparam int DIV_STAGES  = 32;
   localparam int SQRT_STAGES = 16;

   localparam logic [30:0] SPD_MAX = 31'h7FFFFFFF;

   // Register indexes
   localparam logic [2:0] CSR_RADIUS_MIN = 3'd0;
   localparam logic [2:0] CSR_RADIUS_MAX = 3'd1;
   localparam logic [2:0] CSR_MASS       = 3'd2;
   localparam logic [2:0] CSR_VSCALE     = 3'd3;
   localparam logic [2:0] CSR_CULL_SQ    = 3'd4;

   // Context that travels with each request
   typedef struct packed {
      logic        respawn;
      logic        active;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] vel_x;
      logic [31:0] vel_y;
      logic [31:0] vel_z;
      logic [22:0] rad;
      logic [31:0] hgt;
      logic [1:0]  quad;
      logic [30:0] smag;
      logic [30:0] cmag;
   } ctx_type;

   // Horner coefficient used by step k (1..4) of the sine polynomial
   function automatic logic [30:0] sin_coef(input int k);
      logic [30:0] c;
      case (k)
         1: c = SIN_A7;
         2: c = SIN_A5;
         3: c = SIN_A3;
         default: c = SIN_A1;
      endcase
      return c;
   endfunction

endpackage

// File: src/pcor_sin.sv
module pcor_sin import pcor_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  logic [30:0] x,
   output logic [30:0] y
);

   logic [30:0] sx_ff  [SIN_LAT-1];
   logic [30:0] sx2_ff [SIN_LAT-1];
   logic [30:0] st_ff  [SIN_LAT-1];
   logic [30:0] y_ff;
   logic [61:0] sq_prod;
   logic [61:0] fin_prod;
   logic [30:0] y_in;

   always_comb begin
      sq_prod  = 62'(x) * 62'(x);
      fin_prod = 62'(sx_ff[SIN_LAT-2]) * 62'(st_ff[SIN_LAT-2]);
      if (fin_prod[61:30] > 32'(Q30_ONE)) begin
         y_in = Q30_ONE;
      end else begin
         y_in = fin_prod[60:30];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff[0]  <= x;
         sx2_ff[0] <= sq_prod[60:30];
         st_ff[0]  <= SIN_A9;
         y_ff      <= y_in;
      end
   end

   for (genvar k = 1; k < SIN_LAT - 1; k++) begin : g_horner
      logic [61:0] prod;
      logic [30:0] t_in;
      always_comb begin
         prod = 62'(sx2_ff[k-1]) * 62'(st_ff[k-1]);
         t_in = 31'(32'(sin_coef(k)) - prod[61:30]);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sx_ff[k]  <= sx_ff[k-1];
            sx2_ff[k] <= sx2_ff[k-1];
            st_ff[k]  <= t_in;
         end
      end
   end

   assign y = y_ff;

endmodule

// File: src/pcor_divsqrt.sv
module pcor_divsqrt import pcor_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_vld,
   input  ctx_type     in_ctx,
   input  logic [31:0] mass,
   output logic        out_vld,
   output ctx_type     out_ctx,
   output logic [31:0] out_root
);

   // Divider: (mass << 32) / rad, two quotient bits per stage
   logic [DIV_STAGES-1:0] dv_vld_ff;
   ctx_type               dv_ctx_ff [DIV_STAGES];
   logic [22:0]           dv_rem_ff [DIV_STAGES];
   logic [63:0]           dv_quo_ff [DIV_STAGES];
   logic [63:0]           dvd;

   assign dvd = {mass, 32'd0};

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic        vld_s;
      ctx_type     ctx_s;
      logic [22:0] rem_s;
      logic [63:0] quo_s;
      logic [23:0] a1, a2, dv;
      logic        b1, b2;
      logic [22:0] r1, rem_in;

      if (k == 0) begin : g_first
         assign vld_s = in_vld;
         assign ctx_s = in_ctx;
         assign rem_s = '0;
         assign quo_s = '0;
      end else begin : g_next
         assign vld_s = dv_vld_ff[k-1];
         assign ctx_s = dv_ctx_ff[k-1];
         assign rem_s = dv_rem_ff[k-1];
         assign quo_s = dv_quo_ff[k-1];
      end

      always_comb begin
         dv     = {1'b0, ctx_s.rad};
         a1     = {rem_s, dvd[63-2*k]};
         b1     = a1 >= dv;
         r1     = b1 ? 23'(a1 - dv) : a1[22:0];
         a2     = {r1, dvd[62-2*k]};
         b2     = a2 >= dv;
         rem_in = b2 ? 23'(a2 - dv) : a2[22:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[k] <= vld_s;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ctx_ff[k] <= ctx_s;
            dv_rem_ff[k] <= rem_in;
            dv_quo_ff[k] <= {quo_s[61:0], b1, b2};
         end
      end
   end

   // Integer square root of the quotient, two root bits per stage
   logic [SQRT_STAGES-1:0] sq_vld_ff;
   ctx_type                sq_ctx_ff  [SQRT_STAGES];
   logic [63:0]            sq_n_ff    [SQRT_STAGES];
   logic [33:0]            sq_rem_ff  [SQRT_STAGES];
   logic [31:0]            sq_root_ff [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
      logic        vld_s;
      ctx_type     ctx_s;
      logic [63:0] n_s;
      logic [33:0] rem_s;
      logic [31:0] root_s;
      logic [35:0] a1, a2, t1, t2;
      logic        b1, b2;
      logic [33:0] r1, rem_in;
      logic [31:0] q1;

      if (k == 0) begin : g_first
         assign vld_s  = dv_vld_ff[DIV_STAGES-1];
         assign ctx_s  = dv_ctx_ff[DIV_STAGES-1];
         assign n_s    = dv_quo_ff[DIV_STAGES-1];
         assign rem_s  = '0;
         assign root_s = '0;
      end else begin : g_next
         assign vld_s  = sq_vld_ff[k-1];
         assign ctx_s  = sq_ctx_ff[k-1];
         assign n_s    = sq_n_ff[k-1];
         assign rem_s  = sq_rem_ff[k-1];
         assign root_s = sq_root_ff[k-1];
      end

      always_comb begin
         a1     = {rem_s, n_s[63-4*k -: 2]};
         t1     = {2'b00, root_s, 2'b01};
         b1     = a1 >= t1;
         r1     = b1 ? 34'(a1 - t1) : a1[33:0];
         q1     = {root_s[30:0], b1};
         a2     = {r1, n_s[61-4*k -: 2]};
         t2     = {2'b00, q1, 2'b01};
         b2     = a2 >= t2;
         rem_in = b2 ? 34'(a2 - t2) : a2[33:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[k] <= vld_s;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ctx_ff[k]  <= ctx_s;
            sq_n_ff[k]    <= n_s;
            sq_rem_ff[k]  <= rem_in;
            sq_root_ff[k] <= {q1[30:0], b2};
         end
      end
   end

   assign out_vld  = sq_vld_ff[SQRT_STAGES-1];
   assign out_ctx  = sq_ctx_ff[SQRT_STAGES-1];
   assign out_root = sq_root_ff[SQRT_STAGES-1];

endmodule

// File: src/particle_cull_orbit_respawn_top.sv
// Channel   Handshake             Payload
// req       req_valid/req_stall   particle_id, active, pos_x/y/z, vel_x/y/z
// rsp       rsp_valid/rsp_stall   respawned, active_out, new_pos_x/y/z, new_vel_x/y/z
// csr       csr_wen               csr_index, csr_wdata (write only)
//
// One request enters per cycle unless a stalled result freezes the pipeline;
// the 32-stage divider and 16-stage square root give the orbital speed.
// Reset clears the valid bits of every stage and loads the register defaults.
// A stalled result freezes the whole pipeline; req_stall is high only then.
module particle_cull_orbit_respawn_top import pcor_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic        [31:0] req_particle_id,
   input  logic               req_active,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_respawned,
   output logic               rsp_active_out,
   output logic signed [31:0] rsp_new_pos_x,
   output logic signed [31:0] rsp_new_pos_y,
   output logic signed [31:0] rsp_new_pos_z,
   output logic signed [31:0] rsp_new_vel_x,
   output logic signed [31:0] rsp_new_vel_y,
   output logic signed [31:0] rsp_new_vel_z,
   input  logic               csr_wen,
   input  logic        [2:0]  csr_index,
   input  logic        [47:0] csr_wdata
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [22:0] rmin_ff;
   logic [22:0] rmax_ff;
   logic [31:0] mass_ff;
   logic [19:0] vscale_ff;
   logic [47:0] cullsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rmin_ff   <= 23'd1310720;
         rmax_ff   <= 23'd3932160;
         mass_ff   <= 32'd65536000;
         vscale_ff <= 20'd65536;
         cullsq_ff <= 48'd943718400;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_RADIUS_MIN: rmin_ff   <= csr_wdata[22:0];
            CSR_RADIUS_MAX: rmax_ff   <= csr_wdata[22:0];
            CSR_MASS:       mass_ff   <= csr_wdata[31:0];
            CSR_VSCALE:     vscale_ff <= csr_wdata[19:0];
            CSR_CULL_SQ:    cullsq_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Spawn ring span; the ring may be given inverted
   logic        rng_ge;
   logic [22:0] rng_diff;

   assign rng_ge   = rmax_ff >= rmin_ff;
   assign rng_diff = rng_ge ? (rmax_ff - rmin_ff) : (rmin_ff - rmax_ff);

   // ---------------------------------------------------------------
   // Pipeline advance: freeze everything while a result waits
   // ---------------------------------------------------------------
   logic adv;
   logic out_vld_ff;

   assign adv       = !out_vld_ff || !rsp_stall;
   assign req_stall = !adv;

   // ---------------------------------------------------------------
   // Stage 1: capture, take magnitudes, first LCG draw
   // ---------------------------------------------------------------
   logic        p1_vld_ff;
   ctx_type     p1_ctx_ff, p1_ctx_in;
   logic [31:0] p1_ax_ff, p1_ay_ff, p1_az_ff;
   logic [31:0] p1_ax_in, p1_ay_in, p1_az_in;
   logic [31:0] p1_seed_ff, p1_seed_in;

   always_comb begin
      p1_ctx_in        = '0;
      p1_ctx_in.active = req_active;
      p1_ctx_in.pos_x  = req_pos_x;
      p1_ctx_in.pos_y  = req_pos_y;
      p1_ctx_in.pos_z  = req_pos_z;
      p1_ctx_in.vel_x  = req_vel_x;
      p1_ctx_in.vel_y  = req_vel_y;
      p1_ctx_in.vel_z  = req_vel_z;
      p1_ax_in   = req_pos_x[31] ? (~req_pos_x + 32'd1) : req_pos_x;
      p1_ay_in   = req_pos_y[31] ? (~req_pos_y + 32'd1) : req_pos_y;
      p1_az_in   = req_pos_z[31] ? (~req_pos_z + 32'd1) : req_pos_z;
      p1_seed_in = (req_particle_id ^ SEED_MIX) * LCG_MUL + LCG_ADD;
   end

   // ---------------------------------------------------------------
   // Stage 2: squares, second draw
   // ---------------------------------------------------------------
   logic        p2_vld_ff;
   ctx_type     p2_ctx_ff;
   logic [63:0] p2_sqx_ff, p2_sqy_ff, p2_sqz_ff;
   logic [31:0] p2_seed_ff;
   logic [23:0] p2_turn_ff;

   // ---------------------------------------------------------------
   // Stage 3: cull compare, third draw
   // ---------------------------------------------------------------
   logic        p3_vld_ff;
   ctx_type     p3_ctx_ff, p3_ctx_in;
   logic [31:0] p3_seed_ff;
   logic [23:0] p3_u2_ff;
   logic [23:0] p3_turn_ff;
   logic [65:0] d2_sum;

   always_comb begin
      d2_sum = 66'(p2_sqx_ff) + 66'(p2_sqy_ff) + 66'(p2_sqz_ff);
      p3_ctx_in = p2_ctx_ff;
      p3_ctx_in.respawn = p2_ctx_ff.active && (d2_sum > 66'({cullsq_ff, 16'd0}));
   end

   // ---------------------------------------------------------------
   // Stage 4: radius offset product
   // ---------------------------------------------------------------
   logic        p4_vld_ff;
   ctx_type     p4_ctx_ff;
   logic [23:0] p4_u3_ff;
   logic [46:0] p4_rprod_ff;
   logic [23:0] p4_turn_ff;

   // ---------------------------------------------------------------
   // Stage 5: radius, height, quadrant and angle within quadrant
   // ---------------------------------------------------------------
   logic        p5_vld_ff;
   ctx_type     p5_ctx_ff, p5_ctx_in;
   logic [30:0] p5_x_ff;

   always_comb begin
      p5_ctx_in      = p4_ctx_ff;
      p5_ctx_in.rad  = rng_ge ? (rmin_ff + p4_rprod_ff[46:24])
                              : (rmin_ff - p4_rprod_ff[46:24]);
      p5_ctx_in.hgt  = 32'(p4_u3_ff[23:9]) - 32'd16384;
      p5_ctx_in.quad = p4_turn_ff[23:22];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
         p5_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff <= req_valid;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
         p5_vld_ff <= p4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ctx_ff   <= p1_ctx_in;
         p1_ax_ff    <= p1_ax_in;
         p1_ay_ff    <= p1_ay_in;
         p1_az_ff    <= p1_az_in;
         p1_seed_ff  <= p1_seed_in;

         p2_ctx_ff   <= p1_ctx_ff;
         p2_sqx_ff   <= 64'(p1_ax_ff) * 64'(p1_ax_ff);
         p2_sqy_ff   <= 64'(p1_ay_ff) * 64'(p1_ay_ff);
         p2_sqz_ff   <= 64'(p1_az_ff) * 64'(p1_az_ff);
         p2_seed_ff  <= p1_seed_ff * LCG_MUL + LCG_ADD;
         p2_turn_ff  <= p1_seed_ff[23:0];

         p3_ctx_ff   <= p3_ctx_in;
         p3_seed_ff  <= p2_seed_ff * LCG_MUL + LCG_ADD;
         p3_u2_ff    <= p2_seed_ff[23:0];
         p3_turn_ff  <= p2_turn_ff;

         p4_ctx_ff   <= p3_ctx_ff;
         p4_u3_ff    <= p3_seed_ff[23:0];
         p4_rprod_ff <= 47'(p3_u2_ff) * 47'(rng_diff);
         p4_turn_ff  <= p3_turn_ff;

         p5_ctx_ff   <= p5_ctx_in;
         p5_x_ff     <= {1'b0, p4_turn_ff[21:0], 8'd0};
      end
   end

   // ---------------------------------------------------------------
   // Sine of the angle and of its complement (cosine), in Q30
   // ---------------------------------------------------------------
   logic [30:0] sin_f, sin_c;

   pcor_sin u_sin_f (
      .clock (clock),
      .adv   (adv),
      .x     (p5_x_ff),
      .y     (sin_f)
   );

   pcor_sin u_sin_c (
      .clock (clock),
      .adv   (adv),
      .x     (Q30_ONE - p5_x_ff),
      .y     (sin_c)
   );

   // Hold the context alongside the sine pipes
   logic [SIN_LAT-1:0] sd_vld_ff;
   ctx_type            sd_ctx_ff [SIN_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_vld_ff <= '0;
      end else if (adv) begin
         sd_vld_ff <= {sd_vld_ff[SIN_LAT-2:0], p5_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sd_ctx_ff[0] <= p5_ctx_ff;
         for (int i = 1; i < SIN_LAT; i++) begin
            sd_ctx_ff[i] <= sd_ctx_ff[i-1];
         end
      end
   end

   // Pick sine and cosine magnitudes by quadrant
   ctx_type dq_ctx_in;

   always_comb begin
      dq_ctx_in      = sd_ctx_ff[SIN_LAT-1];
      dq_ctx_in.smag = dq_ctx_in.quad[0] ? sin_c : sin_f;
      dq_ctx_in.cmag = dq_ctx_in.quad[0] ? sin_f : sin_c;
   end

   // ---------------------------------------------------------------
   // Orbital speed root: isqrt((mass << 32) / rad)
   // ---------------------------------------------------------------
   logic        dq_vld;
   ctx_type     dq_ctx;
   logic [31:0] dq_root;

   pcor_divsqrt u_divsqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (sd_vld_ff[SIN_LAT-1]),
      .in_ctx   (dq_ctx_in),
      .mass     (mass_ff),
      .out_vld  (dq_vld),
      .out_ctx  (dq_ctx),
      .out_root (dq_root)
   );

   // ---------------------------------------------------------------
   // Stage 6: scale the speed and saturate
   // ---------------------------------------------------------------
   logic        p6_vld_ff;
   ctx_type     p6_ctx_ff;
   logic [30:0] p6_spd_ff, p6_spd_in;
   logic [51:0] spd_prod;

   always_comb begin
      spd_prod  = 52'(dq_root) * 52'(vscale_ff);
      p6_spd_in = (spd_prod[51:16] > 36'(SPD_MAX)) ? SPD_MAX : spd_prod[46:16];
   end

   // ---------------------------------------------------------------
   // Stage 7: magnitude times trig, Q30 down to Q16.16
   // ---------------------------------------------------------------
   logic        p7_vld_ff;
   ctx_type     p7_ctx_ff;
   logic [31:0] p7_mrc_ff, p7_mrs_ff, p7_mvs_ff, p7_mvc_ff;
   logic [61:0] pr_rc, pr_rs, pr_vs, pr_vc;

   always_comb begin
      pr_rc = 62'(p6_ctx_ff.rad) * 62'(p6_ctx_ff.cmag);
      pr_rs = 62'(p6_ctx_ff.rad) * 62'(p6_ctx_ff.smag);
      pr_vs = 62'(p6_spd_ff) * 62'(p6_ctx_ff.smag);
      pr_vc = 62'(p6_spd_ff) * 62'(p6_ctx_ff.cmag);
   end

   // ---------------------------------------------------------------
   // Output stage: apply quadrant signs, select respawn or pass-through
   // ---------------------------------------------------------------
   logic        sneg, cneg;
   logic        out_resp_ff, out_act_ff;
   logic [31:0] out_px_ff, out_py_ff, out_pz_ff, out_vx_ff, out_vy_ff, out_vz_ff;
   logic [31:0] out_px_in, out_py_in, out_pz_in, out_vx_in, out_vy_in, out_vz_in;

   always_comb begin
      sneg = p7_ctx_ff.quad[1];
      cneg = p7_ctx_ff.quad[1] ^ p7_ctx_ff.quad[0];
      if (p7_ctx_ff.respawn) begin
         out_px_in = cneg ? (~p7_mrc_ff + 32'd1) : p7_mrc_ff;
         out_py_in = p7_ctx_ff.hgt;
         out_pz_in = sneg ? (~p7_mrs_ff + 32'd1) : p7_mrs_ff;
         out_vx_in = sneg ? p7_mvs_ff : (~p7_mvs_ff + 32'd1);
         out_vy_in = '0;
         out_vz_in = cneg ? (~p7_mvc_ff + 32'd1) : p7_mvc_ff;
      end else begin
         out_px_in = p7_ctx_ff.pos_x;
         out_py_in = p7_ctx_ff.pos_y;
         out_pz_in = p7_ctx_ff.pos_z;
         out_vx_in = p7_ctx_ff.vel_x;
         out_vy_in = p7_ctx_ff.vel_y;
         out_vz_in = p7_ctx_ff.vel_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p6_vld_ff  <= 1'b0;
         p7_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         p6_vld_ff  <= dq_vld;
         p7_vld_ff  <= p6_vld_ff;
         out_vld_ff <= p7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p6_ctx_ff   <= dq_ctx;
         p6_spd_ff   <= p6_spd_in;

         p7_ctx_ff   <= p6_ctx_ff;
         p7_mrc_ff   <= pr_rc[61:30];
         p7_mrs_ff   <= pr_rs[61:30];
         p7_mvs_ff   <= pr_vs[61:30];
         p7_mvc_ff   <= pr_vc[61:30];

         out_resp_ff <= p7_ctx_ff.respawn;
         out_act_ff  <= p7_ctx_ff.active;
         out_px_ff   <= out_px_in;
         out_py_ff   <= out_py_in;
         out_pz_ff   <= out_pz_in;
         out_vx_ff   <= out_vx_in;
         out_vy_ff   <= out_vy_in;
         out_vz_ff   <= out_vz_in;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_respawned  = out_resp_ff;
   assign rsp_active_out = out_act_ff;
   assign rsp_new_pos_x  = out_px_ff;
   assign rsp_new_pos_y  = out_py_ff;
   assign rsp_new_pos_z  = out_pz_ff;
   assign rsp_new_vel_x  = out_vx_ff;
   assign rsp_new_vel_y  = out_vy_ff;
   assign rsp_new_vel_z  = out_vz_ff;

`ifndef SYNTH
   // A respawned particle always leaves active
   a_resp_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_respawned |-> rsp_active_out)
      else $error("respawned result without active flag");

   // Respawn velocities lie in the x-z plane
   a_resp_vel_y: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_respawned |-> rsp_new_vel_y == 32'sd0)
      else $error("respawned result with nonzero y velocity");

   // An empty output slot never blocks requests
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with output empty");

   // A frozen pipeline holds its first stage
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(p1_vld_ff))
      else $error("first stage moved while stalled");
`endif

endmodule

// File: bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pcor_pkg::*;

   typedef struct {
      logic [31:0] particle_id;
      logic        active;
      logic [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
   } particle_type;

   typedef struct {
      logic        respawned, active_out;
      logic [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
   } outcome_type;

   // Scoreboard: holds a copy of the registers, predicts each request's outcome
   // and compares the block's responses in order.
   class orbit_scoreboard;
      longint unsigned radius_min, radius_max, mass, vscale, cull_sq;
      outcome_type     pending[$];
      int              errors, respawn_count, checked;

      function void set_reg(logic [2:0] idx, logic [47:0] val);
         case (idx)
            CSR_RADIUS_MIN: radius_min = val[22:0];
            CSR_RADIUS_MAX: radius_max = val[22:0];
            CSR_MASS:       mass       = val[31:0];
            CSR_VSCALE:     vscale     = val[19:0];
            CSR_CULL_SQ:    cull_sq    = val;
            default: ;
         endcase
      endfunction

      function longint unsigned quarter_sine(longint unsigned x);
         longint unsigned x2, t;
         x2 = (x * x) >> 30;
         t = 64'd5026995 - ((x2 * 64'd172272) >> 30);
         t = 64'd85569306 - ((x2 * t) >> 30);
         t = 64'd693598669 - ((x2 * t) >> 30);
         t = 64'd1686629713 - ((x2 * t) >> 30);
         t = (x * t) >> 30;
         return (t > 64'd1073741824) ? 64'd1073741824 : t;
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function logic [31:0] scaled(longint unsigned m, longint unsigned trig, bit neg);
         logic [31:0] v;
         v = (m * trig) >> 30;
         return neg ? 32'd0 - v : v;
      endfunction

      function logic [31:0] lcg(ref logic [31:0] s);
         s = s * LCG_MUL + LCG_ADD;
         return s & 32'h00FF_FFFF;
      endfunction

      function void note(particle_type p);
         outcome_type     o;
         longint unsigned ax, ay, az, d2, rad, quo, spd, x, sf, sc, smag, cmag;
         logic [31:0]     s, turn, u2, u3;
         bit              sneg, cneg;
         o = '{1'b0, p.active, p.pos_x, p.pos_y, p.pos_z, p.vel_x, p.vel_y, p.vel_z};
         if (p.active) begin
            ax = {32'd0, (p.pos_x[31] ? 32'd0 - p.pos_x : p.pos_x)};
            ay = {32'd0, (p.pos_y[31] ? 32'd0 - p.pos_y : p.pos_y)};
            az = {32'd0, (p.pos_z[31] ? 32'd0 - p.pos_z : p.pos_z)};
            d2 = ax * ax + ay * ay + az * az;
            if (d2 > (cull_sq << 16)) begin
               s = p.particle_id ^ SEED_MIX;
               turn = lcg(s);
               u2 = lcg(s);
               u3 = lcg(s);
               if (radius_max >= radius_min)
                  rad = radius_min + ((u2 * (radius_max - radius_min)) >> 24);
               else
                  rad = radius_min - ((u2 * (radius_min - radius_max)) >> 24);
               x = longint'(turn[21:0]) << 8;
               sf = quarter_sine(x);
               sc = quarter_sine(64'd1073741824 - x);
               case (turn[23:22])
                  2'd0: begin smag = sf; sneg = 0; cmag = sc; cneg = 0; end
                  2'd1: begin smag = sc; sneg = 0; cmag = sf; cneg = 1; end
                  2'd2: begin smag = sf; sneg = 1; cmag = sc; cneg = 1; end
                  default: begin smag = sc; sneg = 1; cmag = sf; cneg = 0; end
               endcase
               quo = (rad != 0) ? (mass << 32) / rad : 64'hFFFF_FFFF_FFFF_FFFF;
               spd = (int_sqrt(quo) * vscale) >> 16;
               if (spd > 64'h7FFF_FFFF) spd = 64'h7FFF_FFFF;
               o.respawned  = 1'b1;
               o.active_out = 1'b1;
               o.pos_x = scaled(rad, cmag, cneg);
               o.pos_y = (u3 >> 9) - 32'd16384;
               o.pos_z = scaled(rad, smag, sneg);
               o.vel_x = scaled(spd, smag, !sneg);
               o.vel_y = '0;
               o.vel_z = scaled(spd, cmag, cneg);
               respawn_count++;
            end
         end
         pending.push_back(o);
      endfunction

      function void cmp(string name, logic [31:0] e, logic [31:0] a);
         if (e !== a) begin
            $error("%s mismatch: expected %h, got %h", name, e, a);
            errors++;
         end
      endfunction

      function void check(outcome_type a);
         outcome_type e;
         checked++;
         if (pending.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         e = pending.pop_front();
         cmp("respawned", 32'(e.respawned), 32'(a.respawned));
         cmp("active_out", 32'(e.active_out), 32'(a.active_out));
         cmp("new_pos_x", e.pos_x, a.pos_x);
         cmp("new_pos_y", e.pos_y, a.pos_y);
         cmp("new_pos_z", e.pos_z, a.pos_z);
         cmp("new_vel_x", e.vel_x, a.vel_x);
         cmp("new_vel_y", e.vel_y, a.vel_y);
         cmp("new_vel_z", e.vel_z, a.vel_z);
      endfunction
   endclass

   logic               clock, reset;
   logic               req_valid, req_stall, req_active;
   logic        [31:0] req_particle_id;
   logic signed [31:0] req_pos_x, req_pos_y, req_pos_z, req_vel_x, req_vel_y, req_vel_z;
   logic               rsp_valid, rsp_stall, rsp_respawned, rsp_active_out;
   logic signed [31:0] rsp_new_pos_x, rsp_new_pos_y, rsp_new_pos_z;
   logic signed [31:0] rsp_new_vel_x, rsp_new_vel_y, rsp_new_vel_z;
   logic               csr_wen;
   logic        [2:0]  csr_index;
   logic        [47:0] csr_wdata;

   orbit_scoreboard orbits = new();
   bit              burst;      // no idling on either side while set
   bit              hold_rsp;   // request a long receiver hold-off
   int              idle_cycles;

   particle_cull_orbit_respawn_top u_dut (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      rsp_stall <= 1'b1;
      csr_wen   <= 1'b0;
      csr_index <= CSR_RADIUS_MIN;
      csr_wdata <= '0;
      {req_particle_id, req_active} <= '0;
      {req_pos_x, req_pos_y, req_pos_z, req_vel_x, req_vel_y, req_vel_z} <= '0;
   end

   // Check every response taken by the receiver.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         orbits.check('{rsp_respawned, rsp_active_out, rsp_new_pos_x, rsp_new_pos_y,
                        rsp_new_pos_z, rsp_new_vel_x, rsp_new_vel_y, rsp_new_vel_z});
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("tb failed");
         $finish;
      end
   end

   // Receiver: stall a random number of cycles before each response, and once
   // hold off for a long stretch so the pipeline fills and backs up.
   initial begin
      int n;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         n = burst ? 0 : $urandom_range(0, 8);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Offer one request after a random gap; keep it steady until taken.
   task automatic send(particle_type p);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_particle_id <= p.particle_id;
      req_active      <= p.active;
      req_pos_x       <= p.pos_x;
      req_pos_y       <= p.pos_y;
      req_pos_z       <= p.pos_z;
      req_vel_x       <= p.vel_x;
      req_vel_y       <= p.vel_y;
      req_vel_z       <= p.vel_z;
      do @(posedge clock); while (req_stall);
      orbits.note(p);
   endtask

   // Hold the write enable high; the caller drops it after the last write.
   task automatic write_reg(logic [2:0] idx, logic [47:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      orbits.set_reg(idx, val);
   endtask

   // Wait for every outstanding response, then let the pipeline settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (orbits.pending.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   function automatic logic [31:0] coord(int mode);
      case (mode)
         0: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;  // near origin
         1: return $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;  // around the cull ring
         default: return $urandom;                                    // anywhere
      endcase
   endfunction

   function automatic particle_type random_particle();
      particle_type p;
      int           m;
      m = $urandom_range(0, 2);
      p.particle_id = $urandom;
      p.active      = ($urandom_range(0, 9) != 0);
      p.pos_x = coord(m);
      p.pos_y = coord(m);
      p.pos_z = coord(m);
      p.vel_x = $urandom;
      p.vel_y = $urandom;
      p.vel_z = $urandom;
      return p;
   endfunction

   initial begin
      particle_type p;
      logic [47:0]  regs [5];
      int           phase, i;
      orbits.radius_min = 1310720;
      orbits.radius_max = 3932160;
      orbits.mass       = 65536000;
      orbits.vscale     = 65536;
      orbits.cull_sq    = 943718400;
      burst    = 0;
      hold_rsp = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: inactive pass-through, kept inside the ring, extreme positions.
      send('{32'hFFFF_FFFF, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
             32'h8000_0000, 32'h7FFF_FFFF, 32'h0});
      send('{32'h0, 1'b1, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1});
      send('{32'h9E37_79B9, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h0, 32'h0, 32'h0});
      send('{32'h0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      // Just inside and just outside the default ring of 120 units.
      send('{32'h1234_5678, 1'b1, 32'h0078_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
      send('{32'h1234_5678, 1'b1, 32'h0078_0001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
      for (i = 0; i < 12; i++) begin
         p = random_particle();
         p.active = 1'b1;
         p.pos_x  = 32'h4000_0000;
         send(p);
      end

      // Phases: default, wide ring, inverted ring, zero radius with maximum
      // speed, cull everything, cull nothing, then random settings.
      for (phase = 0; phase < 8; phase++) begin
         drain();
         regs = '{48'd1310720, 48'd3932160, 48'd65536000, 48'd65536, 48'd943718400};
         case (phase)
            1: regs = '{48'd0, 48'd7864320, 48'd65536000, 48'd65536, 48'd943718400};
            2: regs = '{48'd7864320, 48'd0, 48'hFFFF_FFFF, 48'd524288, 48'd0};
            3: regs = '{48'd0, 48'd0, 48'hFFFF_FFFF, 48'd524288, 48'd0};
            4: regs = '{48'd65536, 48'd131072, 48'd0, 48'd0, 48'd0};
            5: regs = '{48'h7F_FFFF, 48'h7F_FFFF, 48'd1, 48'hF_FFFF, 48'hFFFF_FFFF_FFFF};
            6, 7: regs = '{48'($urandom_range(0, 7864320)), 48'($urandom_range(0, 7864320)),
                           {16'd0, $urandom}, 48'($urandom_range(0, 524288)),
                           {16'($urandom_range(0, 16'hFFFF)), $urandom}};
            default: ;
         endcase
         if (phase > 0) begin
            for (i = 0; i < 5; i++) write_reg(i[2:0], regs[i]);
            csr_wen <= 1'b0;
         end
         burst = (phase % 3 == 2);
         for (i = 0; i < 85; i++) begin
            if (phase == 1 && i == 20) hold_rsp = 1;
            send(random_particle());
         end
      end

      drain();
      $display("Sent %0d particles over eight register settings; %0d were respawned.",
               orbits.checked, orbits.respawn_count);
      if (orbits.errors == 0 && orbits.pending.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end
endmodule
